// ----- rtl/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg: shared types and codes for the double-ended stack allocator
// Command and status codes, controller states and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsa_pkg;

   // Command codes carried in the request beat
   typedef enum logic [1:0] {
      CMD_ALLOC_FRONT = 2'd0,
      CMD_ALLOC_REAR  = 2'd1,
      CMD_TEMP_ALLOC  = 2'd2,
      CMD_TEMP_FREE   = 2'd3
   } cmd_type;

   // Status codes returned in the response beat
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_FRONT_FULL  = 3'd1,
      ST_REAR_FULL   = 3'd2,
      ST_MARK_EXISTS = 3'd3,
      ST_NO_MARK     = 3'd4
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_MULT = 2'd1,
      S_SIZE = 2'd2,
      S_EXEC = 2'd3
   } state_type;

   // Field widths fixed by the beat format
   localparam int REQ_W    = 16;
   localparam int OFFSET_W = 17;
   localparam int SIZE_W   = 17;
   localparam int HEADER_BYTES = 4;

   // Controller to datapath
   typedef struct packed {
      logic load;   // capture request beat
      logic mult;   // reciprocal multiply stage
      logic size;   // remainder fix and size stage
      logic exec;   // update pointers, write response
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free;  // response register can take a new beat
   } dp_stat_type;

endpackage

// ----- rtl/dsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsa_ctrl: command sequencer
// Steps one request through size rounding and execution; holds the
// execute step until the response register is free.
// ----------------------------------------------------------------------------
module dsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output dsa_pkg::dp_cmd_type  dp_cmd,
   input  dsa_pkg::dp_stat_type dp_stat
);

   dsa_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dsa_pkg::S_IDLE: begin
            if (req_tvalid) state_in = dsa_pkg::S_MULT;
         end
         dsa_pkg::S_MULT: begin
            state_in = dsa_pkg::S_SIZE;
         end
         dsa_pkg::S_SIZE: begin
            state_in = dsa_pkg::S_EXEC;
         end
         dsa_pkg::S_EXEC: begin
            if (dp_stat.slot_free) state_in = dsa_pkg::S_IDLE;
         end
         default: begin
            state_in = dsa_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      dp_cmd     = '0;
      case (state_ff)
         dsa_pkg::S_IDLE: begin
            req_tready  = 1'b1;
            dp_cmd.load = req_tvalid;
         end
         dsa_pkg::S_MULT: begin
            dp_cmd.mult = 1'b1;
         end
         dsa_pkg::S_SIZE: begin
            dp_cmd.size = 1'b1;
         end
         dsa_pkg::S_EXEC: begin
            dp_cmd.exec = dp_stat.slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/dsa_datapath.sv -----
// ----------------------------------------------------------------------------
// dsa_datapath: size rounding, pool pointers and response register
// Rounds the request up to the alignment by a reciprocal multiply, then
// checks fit and moves the front/rear pointers and the mark.
// ----------------------------------------------------------------------------
module dsa_datapath #(
   parameter int POOL_BYTES  = 65536,
   parameter int ALIGN_BYTES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_command,
   input  logic [15:0]          req_request_bytes,
   input  dsa_pkg::dp_cmd_type  dp_cmd,
   output dsa_pkg::dp_stat_type dp_stat,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2:0]           rsp_status,
   output logic [16:0]          rsp_block_offset
);

   // Pointer and compare widths
   localparam int PW    = $clog2(POOL_BYTES + ALIGN_BYTES);
   localparam int CW    = ((PW > dsa_pkg::SIZE_W) ? PW : dsa_pkg::SIZE_W) + 1;
   localparam int SHIFT = dsa_pkg::REQ_W + $clog2(ALIGN_BYTES);
   localparam int MW    = SHIFT + 1;
   localparam int PRODW = dsa_pkg::REQ_W + MW;
   localparam int AW    = $clog2(ALIGN_BYTES) + 2;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << SHIFT) / ALIGN_BYTES);
   // Front top is either aligned or sits HDR_RES past an aligned address
   localparam int HDR_RES   = dsa_pkg::HEADER_BYTES % ALIGN_BYTES;
   localparam int FRONT_PAD = (ALIGN_BYTES - HDR_RES) % ALIGN_BYTES;
   localparam logic [CW-1:0] PAD_C   = CW'(FRONT_PAD);
   localparam logic [CW-1:0] HDR_C   = CW'(dsa_pkg::HEADER_BYTES);
   localparam logic [AW-1:0] ALIGN_C = AW'(ALIGN_BYTES);
   localparam logic [PW-1:0] POOL_C  = PW'(POOL_BYTES);

   // Request capture
   dsa_pkg::cmd_type cmd_ff;
   logic [15:0]      reqb_ff;
   logic [PRODW-1:0] prod_ff;
   logic [dsa_pkg::SIZE_W-1:0] size_ff;

   // Size rounding terms
   logic [15:0]                quot;
   logic [dsa_pkg::SIZE_W-1:0] qa, rem_raw, rem_fix, rounded, size_in;

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff  <= dsa_pkg::cmd_type'(req_command);
         reqb_ff <= req_request_bytes;
      end
      if (dp_cmd.mult) begin
         prod_ff <= PRODW'(reqb_ff) * PRODW'(RECIP);
      end
      if (dp_cmd.size) begin
         size_ff <= size_in;
      end
   end

   // Remainder with one correction step, then round up and add header
   always_comb begin
      quot    = prod_ff[SHIFT +: 16];
      qa      = dsa_pkg::SIZE_W'(quot) * dsa_pkg::SIZE_W'(ALIGN_C);
      rem_raw = dsa_pkg::SIZE_W'(reqb_ff) - qa;
      rem_fix = (rem_raw >= dsa_pkg::SIZE_W'(ALIGN_C))
              ? rem_raw - dsa_pkg::SIZE_W'(ALIGN_C) : rem_raw;
      rounded = (rem_fix == '0) ? dsa_pkg::SIZE_W'(reqb_ff)
              : dsa_pkg::SIZE_W'(reqb_ff) + dsa_pkg::SIZE_W'(ALIGN_C) - rem_fix;
      size_in = rounded + dsa_pkg::SIZE_W'(dsa_pkg::HEADER_BYTES);
   end

   // Pool state
   logic [PW-1:0] front_ff, front_in, rear_ff, rear_in, mark_ff, mark_in;
   logic          unal_ff, unal_in, markv_ff, markv_in;

   // Response register
   logic                 rvalid_ff;
   dsa_pkg::status_type  status_ff, status_in;
   logic [16:0]          offset_ff, offset_in;

   // Execute: fit checks and pointer updates
   logic [CW-1:0] front_al, front_sum, raw_sum, rear_new;
   logic          front_fit, rear_fit;

   always_comb begin
      front_al  = CW'(front_ff) + (unal_ff ? PAD_C : '0);
      front_sum = front_al + CW'(size_ff);
      raw_sum   = CW'(front_ff) + CW'(size_ff);
      rear_new  = CW'(rear_ff) - CW'(size_ff);
      front_fit = front_sum < CW'(rear_ff);
      rear_fit  = raw_sum < CW'(rear_ff);

      front_in  = front_ff;
      unal_in   = unal_ff;
      rear_in   = rear_ff;
      mark_in   = mark_ff;
      markv_in  = markv_ff;
      status_in = dsa_pkg::ST_OK;
      offset_in = '0;

      case (cmd_ff)
         dsa_pkg::CMD_ALLOC_FRONT, dsa_pkg::CMD_TEMP_ALLOC: begin
            if (markv_ff) begin
               status_in = dsa_pkg::ST_MARK_EXISTS;
            end else begin
               // alignment sticks even when the request fails
               front_in = front_al[PW-1:0];
               unal_in  = 1'b0;
               if (!front_fit) begin
                  status_in = dsa_pkg::ST_FRONT_FULL;
               end else begin
                  offset_in = front_al[16:0] + 17'(dsa_pkg::HEADER_BYTES);
                  front_in  = front_sum[PW-1:0];
                  unal_in   = (HDR_RES != 0);
                  if (cmd_ff == dsa_pkg::CMD_TEMP_ALLOC) begin
                     mark_in  = front_al[PW-1:0];
                     markv_in = 1'b1;
                  end
               end
            end
         end
         dsa_pkg::CMD_ALLOC_REAR: begin
            if (!rear_fit) begin
               status_in = dsa_pkg::ST_REAR_FULL;
            end else begin
               rear_in   = rear_new[PW-1:0];
               offset_in = rear_new[16:0] + HDR_C[16:0];
            end
         end
         dsa_pkg::CMD_TEMP_FREE: begin
            if (!markv_ff) begin
               status_in = dsa_pkg::ST_NO_MARK;
            end else begin
               front_in = mark_ff;
               unal_in  = 1'b0;
               markv_in = 1'b0;
            end
         end
         default: begin
            status_in = dsa_pkg::ST_OK;
         end
      endcase
   end

   // Pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         unal_ff  <= 1'b0;
         rear_ff  <= POOL_C;
         mark_ff  <= '0;
         markv_ff <= 1'b0;
      end else if (dp_cmd.exec) begin
         front_ff <= front_in;
         unal_ff  <= unal_in;
         rear_ff  <= rear_in;
         mark_ff  <= mark_in;
         markv_ff <= markv_in;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (dp_cmd.exec) begin
         rvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rvalid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         status_ff <= status_in;
         offset_ff <= offset_in;
      end
   end

   assign dp_stat.slot_free = !rvalid_ff || rsp_tready;
   assign rsp_tvalid        = rvalid_ff;
   assign rsp_status        = status_ff;
   assign rsp_block_offset  = offset_ff;

endmodule

// ----- rtl/double_ended_stack_allocator_core.sv -----
// One request is in flight at a time: a new request beat is taken only once
//   the previous one has gone through its steps (capture, multiply, size,
//   execute); execute waits until the response register is free.
// The next request is taken while an earlier response still waits.
// Reset (synchronous, active high): front at 0, rear at POOL_BYTES, no mark,
//   no response pending.
// ----------------------------------------------------------------------------
// double_ended_stack_allocator_core: two-ended bump allocator over one pool
// Front and rear allocations with header and alignment, plus a temporary
// allocation mark that a free rolls the front back to.
// ----------------------------------------------------------------------------
module double_ended_stack_allocator_core #(
   parameter int POOL_BYTES  = 65536,
   parameter int ALIGN_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [1:0] command, [17:2] request_bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [2:0] status, [19:3] block_offset
);

   dsa_pkg::dp_cmd_type  dp_cmd;
   dsa_pkg::dp_stat_type dp_stat;
   logic [2:0]           rsp_status;
   logic [16:0]          rsp_block_offset;

   // Sequencer
   dsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat)
   );

   // Pool datapath
   dsa_datapath #(
      .POOL_BYTES  (POOL_BYTES),
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_tdata[1:0]),
      .req_request_bytes (req_tdata[17:2]),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_status        (rsp_status),
      .rsp_block_offset  (rsp_block_offset)
   );

   // Response beat packing
   assign rsp_tdata = {4'd0, rsp_block_offset, rsp_status};

endmodule
